[rtl/go_to_pose_controller_assert.svh]
// ---------------------------------------------------------------------------
// Go-to-pose controller assertion macros
// Concurrent checks, compiled away for synthesis.
// ---------------------------------------------------------------------------
`ifndef GO_TO_POSE_CONTROLLER_ASSERT_SVH
`define GO_TO_POSE_CONTROLLER_ASSERT_SVH
`ifndef SYNTHESIS
`define GTP_ASSERT_IMPL(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("%m");
`define GTP_ASSERT_NEXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("%m");
`else
`define GTP_ASSERT_IMPL(label, a, c)
`define GTP_ASSERT_NEXT(label, a, c)
`endif
`endif

[rtl/gtp_pkg.sv]
// ---------------------------------------------------------------------------
// Go-to-pose controller package
// Shared constants, codes and command/status types.
// ---------------------------------------------------------------------------
package gtp_pkg;
  localparam int CordicSteps = 16;
  localparam int StepW = $clog2(CordicSteps + 1);
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 32;

  localparam logic [1:0] OpPose = 2'd0;
  localparam logic [1:0] OpTarget = 2'd1;
  localparam logic [1:0] OpStop = 2'd2;
  localparam logic [1:0] OpUnused = 2'd3;

  localparam logic [CfgIdxW-1:0] RegMaxLin = 3'd0;
  localparam logic [CfgIdxW-1:0] RegMaxAng = 3'd1;
  localparam logic [CfgIdxW-1:0] RegPosTol = 3'd2;
  localparam logic [CfgIdxW-1:0] RegHeadTol = 3'd3;
  localparam logic [CfgIdxW-1:0] RegGain = 3'd4;

  localparam logic signed [17:0] PiQ13 = 18'sd25736;
  localparam logic signed [17:0] HalfPiQ13 = 18'sd12868;
  localparam logic signed [17:0] TwoPiQ13 = 18'sd51472;
  localparam logic signed [21:0] PiQ16 = 22'sd205887;
  localparam logic signed [21:0] TwoPiQ16 = 22'sd411775;

  function automatic logic [16:0] atan_step(input logic [StepW-1:0] i);
    logic [16:0] r;
    case (i)
      0: r = 17'd51472;
      1: r = 17'd30386;
      2: r = 17'd16055;
      3: r = 17'd8150;
      4: r = 17'd4091;
      5: r = 17'd2047;
      6: r = 17'd1024;
      7: r = 17'd512;
      default: r = (i <= 16) ? (17'd1 << (5'd16 - 5'(i))) : 17'd0;
    endcase
    return r;
  endfunction

  typedef struct packed {
    logic load;      // latch pose, compute dx/dy
    logic sq_x;      // square dx
    logic sq_y;      // square dy, accumulate
    logic sq_t;      // square tolerance
    logic cordic_init;
    logic cordic_step;
    logic finish;    // compute result
  } gtp_cmd_t;

  typedef struct packed {
    logic cordic_done;
  } gtp_stat_t;
endpackage

[rtl/gtp_stream_if.sv]
// ---------------------------------------------------------------------------
// Go-to-pose stream interfaces
// Valid/ready channels for pose items and command items.
// ---------------------------------------------------------------------------
interface gtp_in_if;
  logic valid;
  logic ready;
  logic [1:0] op;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [15:0] heading;
  modport source(output valid, op, pos_x, pos_y, heading, input ready);
  modport sink(input valid, op, pos_x, pos_y, heading, output ready);
endinterface

interface gtp_out_if;
  logic valid;
  logic ready;
  logic [15:0] linear_cmd;
  logic signed [15:0] angular_cmd;
  logic arrived;
  logic arrived_changed;
  modport source(output valid, linear_cmd, angular_cmd, arrived, arrived_changed,
                 input ready);
  modport sink(input valid, linear_cmd, angular_cmd, arrived, arrived_changed,
               output ready);
endinterface

[rtl/gtp_datapath.sv]
// ---------------------------------------------------------------------------
// Go-to-pose datapath
// Squared distance, iterative CORDIC bearing and command selection.
// ---------------------------------------------------------------------------
module gtp_datapath (
  input  logic                            clk,
  input  gtp_pkg::gtp_cmd_t               cmd,
  output gtp_pkg::gtp_stat_t              stat,
  input  logic signed [31:0]              pos_x,
  input  logic signed [31:0]              pos_y,
  input  logic signed [15:0]              heading,
  input  logic signed [31:0]              goal_x,
  input  logic signed [31:0]              goal_y,
  input  logic signed [15:0]              goal_heading,
  input  logic [15:0]                     max_linear_speed,
  input  logic [14:0]                     max_angular_speed,
  input  logic [31:0]                     position_tolerance,
  input  logic [14:0]                     heading_tolerance,
  input  logic [15:0]                     turn_gain,
  input  logic [15:0]                     prev_linear,
  input  logic signed [15:0]              prev_angular,
  output logic [15:0]                     linear,
  output logic signed [15:0]              angular,
  output logic                            aligned
);
  // CORDIC x grows by ~1.65 over |v|<=2^33: 36 bits signed safe
  logic signed [35:0] cx, cy;
  logic signed [21:0] cz;
  logic [gtp_pkg::StepW-1:0] step;
  logic signed [32:0] dx, dy;
  logic signed [15:0] ph;
  logic [31:0] ax, ay;
  logic [64:0] dsq;
  logic [63:0] tsq;
  logic [63:0] sq;
  logic [31:0] sq_in;
  logic signed [35:0] xs, ys;
  logic [16:0] at;
  logic signed [21:0] zw;
  logic signed [17:0] bq, e, ew, h, hw, ae, ah;
  logic [31:0] prod;
  logic [14:0] r;
  logic far;
  logic [15:0] linear_n;
  logic signed [15:0] angular_n;
  logic aligned_n;

  // |dx|, |dy| stay below 2^32
  assign ax = dx[32] ? 32'(-dx) : 32'(dx);
  assign ay = dy[32] ? 32'(-dy) : 32'(dy);
  // one 32x32 square per cycle, shared
  assign sq_in = cmd.sq_x ? ax : (cmd.sq_y ? ay : position_tolerance);
  assign sq = 64'(sq_in) * 64'(sq_in);
  assign xs = cx >>> step;
  assign ys = cy >>> step;
  assign at = gtp_pkg::atan_step(step);
  assign stat.cordic_done = (step == gtp_pkg::StepW'(gtp_pkg::CordicSteps));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dx <= 33'(goal_x) - 33'(pos_x);
      dy <= 33'(goal_y) - 33'(pos_y);
      ph <= heading;
    end
    if (cmd.sq_x) dsq <= 65'(sq);
    if (cmd.sq_y) dsq <= dsq + 65'(sq);
    if (cmd.sq_t) tsq <= sq;
    if (cmd.cordic_init) begin
      step <= '0;
      if (dx < 0) begin
        cx <= -36'(dx);
        cy <= -36'(dy);
        cz <= (dy >= 0) ? gtp_pkg::PiQ16 : -gtp_pkg::PiQ16;
      end else begin
        cx <= 36'(dx);
        cy <= 36'(dy);
        cz <= '0;
      end
    end else if (cmd.cordic_step) begin
      step <= step + 1'b1;
      if (cy > 0) begin
        cx <= cx + ys;
        cy <= cy - xs;
        cz <= cz + 22'(at);
      end else begin
        cx <= cx - ys;
        cy <= cy + xs;
        cz <= cz - 22'(at);
      end
    end
    if (cmd.finish) begin
      linear <= linear_n;
      angular <= angular_n;
      aligned <= aligned_n;
    end
  end

  always_comb begin
    zw = cz;
    if (cz > gtp_pkg::PiQ16) zw = cz - gtp_pkg::TwoPiQ16;
    else if (cz < -gtp_pkg::PiQ16) zw = cz + gtp_pkg::TwoPiQ16;
    bq = 18'((zw + 22'sd4) >>> 3);
    e = bq - 18'(ph);
    ew = e;
    if (e > gtp_pkg::PiQ13) ew = e - gtp_pkg::TwoPiQ13;
    else if (e < -gtp_pkg::PiQ13) ew = e + gtp_pkg::TwoPiQ13;
    ae = ew[17] ? -ew : ew;
    h = 18'(goal_heading) - 18'(ph);
    hw = h;
    if (h > gtp_pkg::PiQ13) hw = h - gtp_pkg::TwoPiQ13;
    else if (h < -gtp_pkg::PiQ13) hw = h + gtp_pkg::TwoPiQ13;
    ah = hw[17] ? -hw : hw;
    prod = turn_gain * ae[15:0];
    r = (prod[31:13] > 19'(max_angular_speed)) ? max_angular_speed : prod[27:13];
    far = (dsq > 65'(tsq));
    aligned_n = 1'b0;
    linear_n = prev_linear;
    angular_n = prev_angular;
    if (far) begin
      if (ae > gtp_pkg::HalfPiQ13) begin
        linear_n = '0;
        angular_n = ew[17] ? -16'(max_angular_speed) :
                    ((ew == 0) ? 16'sd0 : 16'(max_angular_speed));
      end else begin
        linear_n = max_linear_speed;
        angular_n = ew[17] ? -16'(r) : ((ew == 0) ? 16'sd0 : 16'(r));
      end
    end else if (ah > 18'(heading_tolerance)) begin
      linear_n = '0;
      angular_n = hw[17] ? -16'(max_angular_speed) :
                  ((hw == 0) ? 16'sd0 : 16'(max_angular_speed));
    end else begin
      aligned_n = 1'b1;
    end
  end
endmodule

[rtl/gtp_control.sv]
// ---------------------------------------------------------------------------
// Go-to-pose controller sequencer
// Handshakes, goal/flag state and datapath sequencing.
// ---------------------------------------------------------------------------
module gtp_control (
  input  logic                 clk,
  input  logic                 rst,
  gtp_in_if.sink               in_ch,
  gtp_out_if.source            out_ch,
  output gtp_pkg::gtp_cmd_t    cmd,
  input  gtp_pkg::gtp_stat_t   stat,
  output logic signed [31:0]   goal_x,
  output logic signed [31:0]   goal_y,
  output logic signed [15:0]   goal_heading,
  output logic [15:0]          last_linear,
  output logic signed [15:0]   last_angular,
  input  logic [15:0]          linear,
  input  logic signed [15:0]   angular,
  input  logic                 aligned,
  output logic                 busy
);
  typedef enum logic [2:0] {IDLE, SQX, SQY, SQT, CORDIC, FIN, EMIT, SEND} state_t;
  state_t state;
  logic reached_flag, reported_flag;

  assign in_ch.ready = (state == IDLE) && !out_ch.valid;
  assign busy = (state != IDLE);

  always_comb begin
    cmd = '0;
    cmd.load = (state == IDLE) && in_ch.valid && in_ch.ready &&
               (in_ch.op == gtp_pkg::OpPose);
    cmd.sq_x = (state == SQX);
    cmd.sq_y = (state == SQY);
    cmd.sq_t = (state == SQT);
    cmd.cordic_init = (state == SQT);
    cmd.cordic_step = (state == CORDIC) && !stat.cordic_done;
    cmd.finish = (state == FIN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      reached_flag <= 1'b1;
      reported_flag <= 1'b0;
      last_linear <= '0;
      last_angular <= '0;
      goal_x <= '0;
      goal_y <= '0;
      goal_heading <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      case (state)
        IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            case (in_ch.op)
              gtp_pkg::OpTarget: begin
                goal_x <= in_ch.pos_x;
                goal_y <= in_ch.pos_y;
                goal_heading <= in_ch.heading;
                reached_flag <= 1'b0;
              end
              gtp_pkg::OpStop: reached_flag <= 1'b1;
              gtp_pkg::OpPose: state <= reached_flag ? SEND : SQX;
              default: ;
            endcase
            if (in_ch.op == gtp_pkg::OpPose && reached_flag) begin
              last_linear <= '0;
              last_angular <= '0;
            end
          end
        end
        SQX: state <= SQY;
        SQY: state <= SQT;
        SQT: state <= CORDIC;
        CORDIC: if (stat.cordic_done) state <= FIN;
        FIN: state <= EMIT;
        EMIT: begin
          last_linear <= linear;
          last_angular <= angular;
          if (aligned) reached_flag <= 1'b1;
          state <= SEND;
        end
        SEND: begin
          out_ch.valid <= 1'b1;
          out_ch.linear_cmd <= last_linear;
          out_ch.angular_cmd <= last_angular;
          out_ch.arrived <= reached_flag;
          out_ch.arrived_changed <= reported_flag != reached_flag;
          reported_flag <= reached_flag;
          state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule

[rtl/go_to_pose_controller.sv]
// Sequence: a measured pose squares dx, dy and the tolerance, runs 16 CORDIC
// iterations plus a done check, then selects (FIN) and registers (EMIT) its
// command before SEND raises the result; straight to SEND when already arrived.
// Throughput: target and stop items every cycle while no result is pending.
// The next is taken once the result is.
// Reset: synchronous active-high rst restores register defaults, arrived set.
// ---------------------------------------------------------------------------
// Go-to-pose controller top level
// Differential-drive go-to-goal steering with configuration registers.
// ---------------------------------------------------------------------------
`include "go_to_pose_controller_assert.svh"
module go_to_pose_controller (
  input  logic                            clk,
  input  logic                            rst,
  gtp_in_if.sink                          in_ch,
  gtp_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [gtp_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [gtp_pkg::CfgDataW-1:0]    cfg_data
);
  logic [15:0] max_linear_speed, turn_gain, last_linear, linear;
  logic [14:0] max_angular_speed, heading_tolerance;
  logic [31:0] position_tolerance;
  logic signed [31:0] goal_x, goal_y;
  logic signed [15:0] goal_heading, last_angular, angular;
  logic aligned, busy;
  gtp_pkg::gtp_cmd_t cmd;
  gtp_pkg::gtp_stat_t stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_linear_speed <= 16'd128;
      max_angular_speed <= 15'd256;
      position_tolerance <= 32'd6554;
      heading_tolerance <= 15'd819;
      turn_gain <= 16'd512;
    end else if (cfg_we) begin
      case (cfg_index)
        gtp_pkg::RegMaxLin: max_linear_speed <= cfg_data[15:0];
        gtp_pkg::RegMaxAng: max_angular_speed <= cfg_data[14:0];
        gtp_pkg::RegPosTol: position_tolerance <= cfg_data;
        gtp_pkg::RegHeadTol: heading_tolerance <= cfg_data[14:0];
        gtp_pkg::RegGain: turn_gain <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  gtp_control u_ctrl (
    .clk, .rst, .in_ch, .out_ch, .cmd, .stat, .goal_x, .goal_y, .goal_heading,
    .last_linear, .last_angular, .linear, .angular, .aligned, .busy
  );

  gtp_datapath u_dp (
    .clk, .cmd, .stat,
    .pos_x(in_ch.pos_x), .pos_y(in_ch.pos_y), .heading(in_ch.heading),
    .goal_x, .goal_y, .goal_heading, .max_linear_speed, .max_angular_speed,
    .position_tolerance, .heading_tolerance, .turn_gain,
    .prev_linear(last_linear), .prev_angular(last_angular),
    .linear, .angular, .aligned
  );

  `GTP_ASSERT_IMPL(a_no_accept_busy, busy, !in_ch.ready)
  `GTP_ASSERT_NEXT(a_out_hold, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.linear_cmd))
  `GTP_ASSERT_NEXT(a_out_after_pose, cmd.finish, busy)
endmodule
